// File: hw/rtl/indexed_pixel_to_rgb565_palette_defines.svh
// ----------------------------------------------------------------------------
// Palette lookup assertion macros
// Shared property wrappers for the palette lookup block, clocked on the
// rising edge of clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INDEXED_PIXEL_TO_RGB565_PALETTE_DEFINES_SVH
`define INDEXED_PIXEL_TO_RGB565_PALETTE_DEFINES_SVH

// Same-cycle implication
`define IPAL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define IPAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ipal_pkg.sv
// ----------------------------------------------------------------------------
// Palette lookup package
// Item codes, luminance and dimming constants, and the RGB565 packing
// function shared by the palette lookup block and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package ipal_pkg;

   // Palette geometry
   localparam int unsigned PALETTE_ENTRIES = 256;
   localparam int unsigned INDEX_W         = 8;
   localparam int unsigned CHAN_W          = 8;
   localparam int unsigned WORD_W          = 16;

   // Item kind
   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_PIXEL = 1'b1
   } kind_type;

   // RGB565 channel masks
   localparam logic [7:0] RED_MASK = 8'hF8;
   localparam logic [7:0] GRN_MASK = 8'hFC;

   // Luminance weights, sum scaled by 256
   localparam int unsigned LUM_R_COEF = 77;
   localparam int unsigned LUM_G_COEF = 150;
   localparam int unsigned LUM_B_COEF = 29;
   localparam int unsigned LUM_SUM_W  = 16;

   // Dimmed gray: base + lum * num / den
   localparam int unsigned GRAY_BASE = 18;
   localparam int unsigned DIM_NUM   = 45;
   localparam int unsigned DIM_DEN   = 100;
   localparam int unsigned GRAY_MAX  = GRAY_BASE + (255 * DIM_NUM) / DIM_DEN;

   // Divide by DIM_DEN via reciprocal; exact for all 8-bit lum values
   localparam int unsigned DIM_SHIFT  = 19;
   localparam int unsigned DIM_RECIP  = ((1 << DIM_SHIFT) + DIM_DEN - 1) / DIM_DEN;
   localparam int unsigned DIM_MULT   = DIM_NUM * DIM_RECIP;
   localparam int unsigned DIM_PROD_W = 26;

   // Pack 8-bit channels to RGB565 and swap its bytes
   function automatic logic [WORD_W-1:0] pack_swapped(
      input logic [CHAN_W-1:0] r,
      input logic [CHAN_W-1:0] g,
      input logic [CHAN_W-1:0] b
   );
      logic [WORD_W-1:0] c;
      c = (WORD_W'(r & RED_MASK) << 8) | (WORD_W'(g & GRN_MASK) << 3) | WORD_W'(b >> 3);
      return {c[7:0], c[15:8]};
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ipal_if.sv
// ----------------------------------------------------------------------------
// Palette lookup channels
// Valid/ready channels for palette requests (writes and pixels) and for
// translated pixel responses.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: palette write or pixel to translate
interface ipal_req_if;
   logic                            valid;
   logic                            ready;
   logic [0:0]                      kind;
   logic [ipal_pkg::INDEX_W-1:0]    color_index;
   logic [ipal_pkg::CHAN_W-1:0]     red;
   logic [ipal_pkg::CHAN_W-1:0]     green;
   logic [ipal_pkg::CHAN_W-1:0]     blue;

   modport source (output valid, kind, color_index, red, green, blue, input ready);
   modport sink   (input valid, kind, color_index, red, green, blue, output ready);
endinterface

// Response channel: stored color and gray words
interface ipal_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ipal_pkg::WORD_W-1:0]     color_word;
   logic [ipal_pkg::WORD_W-1:0]     gray_word;

   modport source (output valid, color_word, gray_word, input ready);
   modport sink   (input valid, color_word, gray_word, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/indexed_pixel_to_rgb565_palette.sv
// ----------------------------------------------------------------------------
// Indexed pixel to RGB565 palette lookup
// Palette RAM of color and dimmed-gray words, written by palette beats and
// read by pixel beats.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries two kinds of beat. A write beat (kind 0) loads palette
//   entry color_index with the byte-swapped RGB565 of red/green/blue and a
//   byte-swapped dimmed gray of the same color; it returns nothing. A pixel
//   beat (kind 1) returns one rsp_chan beat with both stored words of entry
//   color_index, or zeros when the index is past the palette.
//   Beats pass three stages in order: luminance, gray scaling plus palette
//   RAM access, and the registered RAM read that drives rsp_chan.
//   Throughput is one beat per cycle while rsp_chan does not stall, writes
//   and pixels mixed freely; the single RAM access stage keeps reads and
//   writes in order, so a pixel right after a write to the same entry sees
//   the new value.
//   A stall on rsp_chan holds the response; bubbles in front of it still
//   fill, and req_chan.ready drops only when every stage holds a beat.
//   Reset empties the pipeline. The palette RAM is not cleared: an entry
//   reads as garbage until it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_pixel_to_rgb565_palette_defines.svh"

module indexed_pixel_to_rgb565_palette #(
   parameter int unsigned PALETTE_ENTRIES = ipal_pkg::PALETTE_ENTRIES
) (
   input  wire          clock,
   input  wire          reset,
   ipal_req_if.sink     req_chan,
   ipal_rsp_if.source   rsp_chan
);

   localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

   // Palette RAMs
   logic [ipal_pkg::WORD_W-1:0] color_mem [PALETTE_ENTRIES];
   logic [ipal_pkg::WORD_W-1:0] gray_mem  [PALETTE_ENTRIES];

   // Stage 1: luminance
   logic                         v1_ff, v1_in;
   ipal_pkg::kind_type           kind1_ff;
   logic                         ok1_ff;
   logic [AW-1:0]                idx1_ff;
   logic [7:0]                   lum1_ff;
   logic [ipal_pkg::WORD_W-1:0]  color1_ff;

   // Stage 2: gray, RAM access
   logic                         v2_ff, v2_in;
   ipal_pkg::kind_type           kind2_ff;
   logic                         ok2_ff;
   logic [AW-1:0]                idx2_ff;
   logic [7:0]                   gray2_ff;
   logic [ipal_pkg::WORD_W-1:0]  color2_ff;

   // Output stage: registered RAM read
   logic                         vo_ff, vo_in;
   logic                         zero_ff;
   logic [ipal_pkg::WORD_W-1:0]  rd_color_ff;
   logic [ipal_pkg::WORD_W-1:0]  rd_gray_ff;

   // Handshake and datapath nets
   logic                           accept;
   logic                           go_out;
   logic                           move2;
   logic                           move1;
   logic                           in_range;
   logic [ipal_pkg::LUM_SUM_W-1:0] lum_sum;
   logic [ipal_pkg::DIM_PROD_W-1:0] dim_prod;
   logic [7:0]                     gray_in;

   // Stage flow: a stage moves on when the one after it is free
   always_comb begin
      go_out = !vo_ff || rsp_chan.ready;
      move2  = v2_ff && (kind2_ff == ipal_pkg::KIND_WRITE || go_out);
      move1  = v1_ff && (!v2_ff || move2);
      accept = req_chan.valid && req_chan.ready;
      v1_in  = accept || (v1_ff && !move1);
      v2_in  = move1 || (v2_ff && !move2);
      vo_in  = (move2 && kind2_ff == ipal_pkg::KIND_PIXEL) || (vo_ff && !rsp_chan.ready);
   end

   assign req_chan.ready = !v1_ff || move1;

   // Luminance sum and range check on the incoming beat
   always_comb begin
      in_range = {1'b0, req_chan.color_index} < (ipal_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);
      lum_sum  = ipal_pkg::LUM_SUM_W'(ipal_pkg::LUM_R_COEF) * ipal_pkg::LUM_SUM_W'(req_chan.red)
               + ipal_pkg::LUM_SUM_W'(ipal_pkg::LUM_G_COEF) * ipal_pkg::LUM_SUM_W'(req_chan.green)
               + ipal_pkg::LUM_SUM_W'(ipal_pkg::LUM_B_COEF) * ipal_pkg::LUM_SUM_W'(req_chan.blue);
   end

   // Dimmed gray: 18 + lum * 45 / 100 by reciprocal multiply
   always_comb begin
      dim_prod = ipal_pkg::DIM_PROD_W'(lum1_ff) * ipal_pkg::DIM_PROD_W'(ipal_pkg::DIM_MULT);
      gray_in  = 8'(ipal_pkg::GRAY_BASE)
               + 8'(dim_prod[ipal_pkg::DIM_PROD_W-1:ipal_pkg::DIM_SHIFT]);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         vo_ff <= vo_in;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind1_ff  <= ipal_pkg::kind_type'(req_chan.kind);
         ok1_ff    <= in_range;
         idx1_ff   <= req_chan.color_index[AW-1:0];
         lum1_ff   <= lum_sum[ipal_pkg::LUM_SUM_W-1:8];
         color1_ff <= ipal_pkg::pack_swapped(req_chan.red, req_chan.green, req_chan.blue);
      end
   end

   // Stage 2 payload
   always_ff @(posedge clock) begin
      if (move1) begin
         kind2_ff  <= kind1_ff;
         ok2_ff    <= ok1_ff;
         idx2_ff   <= idx1_ff;
         gray2_ff  <= gray_in;
         color2_ff <= color1_ff;
      end
   end

   // Palette RAM write
   always_ff @(posedge clock) begin
      if (move2 && kind2_ff == ipal_pkg::KIND_WRITE && ok2_ff) begin
         color_mem[idx2_ff] <= color2_ff;
         gray_mem[idx2_ff]  <= ipal_pkg::pack_swapped(gray2_ff, gray2_ff, gray2_ff);
      end
   end

   // Palette RAM read into the response register
   always_ff @(posedge clock) begin
      if (move2 && kind2_ff == ipal_pkg::KIND_PIXEL) begin
         zero_ff <= !ok2_ff;
         if (ok2_ff) begin
            rd_color_ff <= color_mem[idx2_ff];
            rd_gray_ff  <= gray_mem[idx2_ff];
         end
      end
   end

   // Response beat; out-of-range pixels read as zero
   assign rsp_chan.valid      = vo_ff;
   assign rsp_chan.color_word = zero_ff ? '0 : rd_color_ff;
   assign rsp_chan.gray_word  = zero_ff ? '0 : rd_gray_ff;

   // Checks
   `IPAL_ASSERT_IMP(a_stall_only_when_full, !req_chan.ready, v1_ff && v2_ff && vo_ff && !rsp_chan.ready, "request stalled with a bubble in the pipeline")
   `IPAL_ASSERT_NEXT(a_write_no_rsp, v2_ff && kind2_ff == ipal_pkg::KIND_WRITE && !vo_ff, !rsp_chan.valid, "palette write produced a response beat")
   `IPAL_ASSERT_NEXT(a_pixel_gives_rsp, v2_ff && kind2_ff == ipal_pkg::KIND_PIXEL && go_out, rsp_chan.valid, "pixel beat lost at RAM access stage")
   `IPAL_ASSERT_IMP(a_gray_bound, v2_ff, gray2_ff <= 8'(ipal_pkg::GRAY_MAX), "dimmed gray above its maximum")

endmodule

`default_nettype wire
